### hw/rtl/bth_pkg.sv
// Shared types, constants and state encoding for the boundary tag heap allocator.
`timescale 1ns / 1ps

package bth_pkg;

    localparam int BTH_HEAP_WORDS = 16384;

    localparam int OFF_W  = 32;
    localparam int TAG_W  = 32;
    localparam int NEED_W = 17;

    localparam int WORD  = 4;
    localparam int DWORD = 8;

    localparam logic [TAG_W-1:0] TAG_ALLOC = 32'h0000_0001;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] req_size;
        logic [15:0] free_addr;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] payload_addr;
        logic [1:0]  status;
    } t_out_beat;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [OFF_W-1:0] addr;
        logic [TAG_W-1:0] wdata;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_TAKE_W,
        S_SPLIT_W1,
        S_SPLIT_W2,
        S_SPLIT_W3,
        S_GROW_CHK,
        S_GROW_W1,
        S_GROW_W2,
        S_FREE_RD,
        S_FREE_HDR,
        S_FREE_FTR,
        S_FREE_PRD,
        S_FREE_PCHK,
        S_MERGE_W
    } t_state;

endpackage

### hw/rtl/bth_ram.sv
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module bth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bth_engine.sv
// Command sequencer that walks, splits, grows and frees blocks through the tag memory port.
`timescale 1ns / 1ps

module bth_engine import bth_pkg::*; #(
    parameter int HEAP_WORDS = BTH_HEAP_WORDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_hold,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_beat,
    output t_mem_req         o_mem,
    input  logic [TAG_W-1:0] i_mem_rdata,
    output logic             o_res_valid,
    output t_out_beat        o_res,
    input  logic             i_res_ack
);

    localparam int HEAP_BYTES = HEAP_WORDS * WORD;
    localparam int HE_W       = $clog2(HEAP_BYTES + 1);

    t_state            r_state, n_state;
    logic [HE_W-1:0]   r_heap_end, n_heap_end;
    logic [NEED_W-1:0] r_need, n_need;
    logic [OFF_W-1:0]  r_pos, n_pos;
    logic [TAG_W-1:0]  r_t, n_t;
    logic [TAG_W-1:0]  r_v, n_v;
    t_out_beat         r_res, n_res;
    logic              r_done, n_done;

    logic [NEED_W-1:0] need_sum;
    logic [NEED_W-1:0] need_c;
    logic [OFF_W-1:0]  heap_end32;
    logic [OFF_W-1:0]  endmark;
    logic [OFF_W-1:0]  need32;
    logic [OFF_W-1:0]  sz32;
    logic [OFF_W-1:0]  rd_sz32;
    logic [TAG_W-1:0]  alloc_tag;
    logic [TAG_W-1:0]  rest_tag;
    logic [OFF_W-1:0]  merge_sum;
    logic [TAG_W-1:0]  merge_tag;
    logic [OFF_W-1:0]  pay_addr32;
    t_out_beat         ok_none;

    assign need_sum   = NEED_W'(i_in_beat.req_size) + NEED_W'(15);
    assign need_c     = {need_sum[NEED_W-1:3], 3'b000};
    assign heap_end32 = OFF_W'(r_heap_end);
    assign endmark    = heap_end32 - OFF_W'(WORD);
    assign need32     = OFF_W'(r_need);
    assign sz32       = OFF_W'(r_t[TAG_W-1:3]);
    assign rd_sz32    = OFF_W'(i_mem_rdata[TAG_W-1:3]);
    assign alloc_tag  = TAG_W'({r_need, 3'b000}) | TAG_ALLOC;
    assign rest_tag   = TAG_W'({sz32 - need32, 3'b000});
    assign merge_sum  = sz32 + rd_sz32;
    assign merge_tag  = {merge_sum[OFF_W-4:0], 3'b000};
    assign pay_addr32 = r_pos + OFF_W'(WORD);
    assign ok_none    = '{payload_addr: 16'd0, status: ST_OK};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_heap_end <= HE_W'(DWORD);
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_heap_end <= n_heap_end;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need <= n_need;
        r_pos  <= n_pos;
        r_t    <= n_t;
        r_v    <= n_v;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_heap_end  = r_heap_end;
        n_need      = r_need;
        n_pos       = r_pos;
        n_t         = r_t;
        n_v         = r_v;
        n_res       = r_res;
        n_done      = r_done;
        o_mem       = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    o_res_valid = 1'b1;
                    if (i_res_ack) begin
                        n_done = 1'b0;
                    end
                end else begin
                    o_in_ready = !i_hold;
                    if (i_in_valid && !i_hold) begin
                        if (i_in_beat.cmd == CMD_ALLOC) begin
                            if (i_in_beat.req_size == 16'd0) begin
                                n_res  = '{payload_addr: 16'd0, status: ST_ZERO};
                                n_done = 1'b1;
                            end else begin
                                n_need  = need_c;
                                n_pos   = OFF_W'(WORD);
                                n_state = S_WALK_RD;
                            end
                        end else begin
                            if ((i_in_beat.free_addr < 16'(DWORD))
                                    || (i_in_beat.free_addr[1:0] != 2'b00)
                                    || (OFF_W'(i_in_beat.free_addr) >= heap_end32)) begin
                                n_res  = ok_none;
                                n_done = 1'b1;
                            end else begin
                                n_pos   = OFF_W'(i_in_beat.free_addr) - OFF_W'(WORD);
                                n_state = S_FREE_RD;
                            end
                        end
                    end
                end
            end
            S_WALK_RD: begin
                if (r_pos < endmark) begin
                    o_mem   = '{en: 1'b1, we: 1'b0, addr: r_pos, wdata: '0};
                    n_state = S_WALK_CHK;
                end else begin
                    n_state = S_GROW_CHK;
                end
            end
            S_WALK_CHK: begin
                n_t = i_mem_rdata;
                if (rd_sz32 == '0) begin
                    n_state = S_GROW_CHK;
                end else if (!i_mem_rdata[0] && (rd_sz32 >= need32)
                        && (rd_sz32 < (need32 << 1))) begin
                    o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos,
                                wdata: i_mem_rdata | TAG_ALLOC};
                    n_state = S_TAKE_W;
                end else if (!i_mem_rdata[0] && (rd_sz32 >= (need32 << 1))
                        && (rd_sz32 < (need32 << 2))) begin
                    o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos, wdata: alloc_tag};
                    n_state = S_SPLIT_W1;
                end else begin
                    n_pos   = r_pos + rd_sz32;
                    n_state = S_WALK_RD;
                end
            end
            S_TAKE_W: begin
                o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos + sz32 - OFF_W'(WORD),
                            wdata: r_t | TAG_ALLOC};
                n_res   = '{payload_addr: pay_addr32[15:0], status: ST_OK};
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SPLIT_W1: begin
                o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos + need32 - OFF_W'(WORD),
                            wdata: alloc_tag};
                n_state = S_SPLIT_W2;
            end
            S_SPLIT_W2: begin
                o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos + need32, wdata: rest_tag};
                n_state = S_SPLIT_W3;
            end
            S_SPLIT_W3: begin
                o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos + sz32 - OFF_W'(WORD),
                            wdata: rest_tag};
                n_res   = '{payload_addr: pay_addr32[15:0], status: ST_OK};
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_GROW_CHK: begin
                if ((heap_end32 + need32) > OFF_W'(HEAP_BYTES)) begin
                    n_res   = '{payload_addr: 16'd0, status: ST_FULL};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_mem   = '{en: 1'b1, we: 1'b1, addr: endmark, wdata: alloc_tag};
                    n_state = S_GROW_W1;
                end
            end
            S_GROW_W1: begin
                o_mem   = '{en: 1'b1, we: 1'b1, addr: endmark + need32 - OFF_W'(WORD),
                            wdata: alloc_tag};
                n_state = S_GROW_W2;
            end
            S_GROW_W2: begin
                o_mem      = '{en: 1'b1, we: 1'b1, addr: endmark + need32, wdata: TAG_ALLOC};
                n_heap_end = HE_W'(heap_end32 + need32);
                n_res      = '{payload_addr: heap_end32[15:0], status: ST_OK};
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            S_FREE_RD: begin
                o_mem   = '{en: 1'b1, we: 1'b0, addr: r_pos, wdata: '0};
                n_state = S_FREE_HDR;
            end
            S_FREE_HDR: begin
                n_t     = i_mem_rdata;
                o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos, wdata: i_mem_rdata & ~TAG_ALLOC};
                n_state = S_FREE_FTR;
            end
            S_FREE_FTR: begin
                o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos + sz32 - OFF_W'(WORD),
                            wdata: r_t & ~TAG_ALLOC};
                n_state = S_FREE_PRD;
            end
            S_FREE_PRD: begin
                o_mem   = '{en: 1'b1, we: 1'b0, addr: r_pos - OFF_W'(WORD), wdata: '0};
                n_state = S_FREE_PCHK;
            end
            S_FREE_PCHK: begin
                if (!i_mem_rdata[0]) begin
                    n_v = merge_tag;
                    if (rd_sz32 <= r_pos) begin
                        o_mem = '{en: 1'b1, we: 1'b1, addr: r_pos - rd_sz32, wdata: merge_tag};
                    end
                    n_state = S_MERGE_W;
                end else begin
                    n_res   = ok_none;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MERGE_W: begin
                o_mem   = '{en: 1'b1, we: 1'b1, addr: r_pos + sz32 - OFF_W'(WORD), wdata: r_v};
                n_res   = ok_none;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

### hw/rtl/boundary_tag_heap_allocator_core.sv
// Top level of the boundary tag heap allocator: tag RAM, clearing sweep and output register.
`timescale 1ns / 1ps

// Heap allocator over a tag RAM of HEAP_WORDS 32-bit words, one command per input beat and
// one result beat per command. The walk takes the first free block whose size is at least the
// need and under four times it. After reset the tag RAM is cleared by a sweep over all
// HEAP_WORDS words, during which input is stalled. All tag traffic shares the single port of
// the tag RAM, one access per cycle with a registered read. A zero-size allocate or an ignored
// free only takes the beat and hands off the result. A free reads the header, clears the
// header and the footer, reads the previous tag and, when that block is free, merges with it.
// An allocate takes the beat, reads and then checks each tag on its walk, writes the tags of
// the taken, split or grown block or finds the heap full, and hands off the result. The next
// input beat can be taken while the previous result beat still waits in the output register.

module boundary_tag_heap_allocator_core import bth_pkg::*; #(
    parameter int HEAP_WORDS = BTH_HEAP_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int AW = $clog2(HEAP_WORDS);

    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_idx;
    logic             r_rd_ok;
    logic             r_out_valid;
    t_out_beat        r_out_data;

    t_mem_req         eng_mem;
    logic [TAG_W-1:0] ram_q;
    logic [TAG_W-1:0] eng_rdata;
    logic             eng_ready;
    logic             eng_res_valid;
    t_out_beat        eng_res;
    logic             out_free;
    logic             in_range;

    logic             ram_en;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [TAG_W-1:0] ram_wdata;

    assign in_range = eng_mem.addr[OFF_W-1:2] < (OFF_W-2)'(HEAP_WORDS);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_clr_busy) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = r_clr_idx;
            ram_wdata = (r_clr_idx < AW'(2)) ? TAG_ALLOC : '0;
        end else begin
            ram_en    = eng_mem.en && in_range;
            ram_we    = eng_mem.we;
            ram_addr  = eng_mem.addr[AW+1:2];
            ram_wdata = eng_mem.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == AW'(HEAP_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_mem.en && !eng_mem.we) begin
            r_rd_ok <= in_range;
        end
    end

    assign eng_rdata = r_rd_ok ? ram_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_valid && out_free) begin
            r_out_data <= eng_res;
        end
    end

    bth_ram #(
        .WIDTH(TAG_W),
        .DEPTH(HEAP_WORDS)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_q)
    );

    bth_engine #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (r_clr_busy),
        .i_in_valid (i_in_valid),
        .o_in_ready (eng_ready),
        .i_in_beat  (i_in_data),
        .o_mem      (eng_mem),
        .i_mem_rdata(eng_rdata),
        .o_res_valid(eng_res_valid),
        .o_res      (eng_res),
        .i_res_ack  (out_free)
    );

    assign o_in_stall  = !eng_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hw/rtl/bth_checker.sv
// Port-level assertions for the boundary tag heap allocator and their bind to the top level.
`timescale 1ns / 1ps

module bth_checker import bth_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("Result beat dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("Result beat changed while stalled.");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK))
            |-> ((o_out_data.payload_addr == 16'd0)
                 && ((o_out_data.status == ST_ZERO) || (o_out_data.status == ST_FULL))))
        else $error("Failed allocate carries an address or an unknown status.");

    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.payload_addr[2:0] == 3'b000))
        else $error("Payload address is not aligned to a double word.");

    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.cmd == CMD_ALLOC || i_in_data.cmd == CMD_FREE))
            |=> o_in_stall)
        else $error("Input beat taken while a command is still in progress.");

endmodule

bind boundary_tag_heap_allocator_core bth_checker u_bth_checker (.*);

### sim/heap_alloc_checker.sv
// Checker for the boundary tag heap allocator: heap tag predictor and result comparison.
`timescale 1ns / 1ps

module heap_alloc_checker import bth_pkg::*; #(
    parameter int HEAP_WORDS = BTH_HEAP_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_mismatches,
    output int        o_waiting
);

    logic [TAG_W-1:0] tag_mem [HEAP_WORDS];
    logic [31:0]      heap_used;
    t_out_beat        owed_results [$];

    function automatic logic [31:0] tag_get(input logic [31:0] off);
        logic [31:0] idx;
        idx = off >> 2;
        if (idx >= HEAP_WORDS) return '0;
        return tag_mem[idx];
    endfunction

    function automatic void tag_put(input logic [31:0] off, input logic [31:0] val);
        logic [31:0] idx;
        idx = off >> 2;
        if (idx < HEAP_WORDS) tag_mem[idx] = val;
    endfunction

    function automatic void heap_clear();
        for (int i = 0; i < HEAP_WORDS; i++) tag_mem[i] = '0;
        tag_mem[0] = TAG_ALLOC;
        tag_mem[1] = TAG_ALLOC;
        heap_used = 32'(2 * WORD);
    endfunction

    function automatic t_out_beat heap_alloc(input logic [15:0] req);
        logic [31:0] need, pos, endmark, t, sz, v, rest;
        t_out_beat r;
        r.payload_addr = '0;
        r.status = ST_OK;
        if (req == 16'd0) begin
            r.status = ST_ZERO;
            return r;
        end
        need = ({16'd0, req} + 32'(2 * DWORD - 1)) & ~32'(DWORD - 1);
        endmark = heap_used - WORD;
        pos = WORD;
        while (pos < endmark) begin
            t = tag_get(pos);
            sz = t >> 3;
            if (sz == 0) break;
            if (t[0] == 1'b0) begin
                if (sz >= need && sz < 2 * need) begin
                    tag_put(pos, t | TAG_ALLOC);
                    tag_put(pos + sz - WORD, t | TAG_ALLOC);
                    r.payload_addr = 16'(pos + WORD);
                    return r;
                end
                if (sz >= 2 * need && sz < 4 * need) begin
                    v = (need << 3) | TAG_ALLOC;
                    tag_put(pos, v);
                    tag_put(pos + need - WORD, v);
                    rest = sz - need;
                    tag_put(pos + need, rest << 3);
                    tag_put(pos + need + rest - WORD, rest << 3);
                    r.payload_addr = 16'(pos + WORD);
                    return r;
                end
            end
            pos = pos + sz;
        end
        if (heap_used + need > 32'(HEAP_WORDS * WORD)) begin
            r.status = ST_FULL;
            return r;
        end
        v = (need << 3) | TAG_ALLOC;
        tag_put(endmark, v);
        tag_put(endmark + need - WORD, v);
        tag_put(endmark + need, TAG_ALLOC);
        heap_used = heap_used + need;
        r.payload_addr = 16'(endmark + WORD);
        return r;
    endfunction

    function automatic void heap_free(input logic [15:0] fad);
        logic [31:0] addr, hdr, t, sz, cleared, pt, psz, v;
        addr = {16'd0, fad};
        if (addr < 2 * WORD || addr[1:0] != 2'b00 || addr >= heap_used) return;
        hdr = addr - WORD;
        t = tag_get(hdr);
        sz = t >> 3;
        cleared = t & ~TAG_ALLOC;
        tag_put(hdr, cleared);
        tag_put(hdr + sz - WORD, cleared);
        pt = tag_get(hdr - WORD);
        if (pt[0] == 1'b0) begin
            psz = pt >> 3;
            v = (sz + psz) << 3;
            if (psz <= hdr) tag_put(hdr - psz, v);
            tag_put(hdr + sz - WORD, v);
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_out_beat want;
        if (!i_rst_n) begin
            heap_clear();
            owed_results.delete();
            o_mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    $display("%0t: unexpected result beat, expected none, got addr %h status %0d",
                             $time, i_out_data.payload_addr, i_out_data.status);
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_data.payload_addr !== want.payload_addr) begin
                        o_mismatches = o_mismatches + 1;
                        $display("%0t: payload_addr expected %h, got %h",
                                 $time, want.payload_addr, i_out_data.payload_addr);
                    end
                    if (i_out_data.status !== want.status) begin
                        o_mismatches = o_mismatches + 1;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_out_data.status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.cmd == CMD_ALLOC) begin
                    owed_results.push_back(heap_alloc(i_in_data.req_size));
                end else begin
                    heap_free(i_in_data.free_addr);
                    want.payload_addr = '0;
                    want.status = ST_OK;
                    owed_results.push_back(want);
                end
            end
        end
        o_waiting = owed_results.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for the boundary tag heap allocator: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_top import bth_pkg::*; ();

    localparam int IDLE_LIMIT = 200000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_data;

    int          chk_errors;
    int          chk_waiting;
    logic        calm = 1'b0;
    int          stall_hold = 0;
    int          idle_cycles = 0;
    logic        cmd_log [$];
    logic [15:0] live_addrs [$];
    int          n_granted = 0;
    int          n_zero = 0;
    int          n_full = 0;
    int          n_freed = 0;

    always #6 clk = ~clk;

    boundary_tag_heap_allocator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    heap_alloc_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_mismatches (chk_errors),
        .o_waiting    (chk_waiting)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] small_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 16'($urandom_range(1, 64));
        if (r < 98) return 16'($urandom_range(65, 1024));
        return 16'($urandom_range(1025, 8192));
    endfunction

    task automatic send_beat(input logic cmd, input logic [15:0] req, input logic [15:0] fad);
        t_in_beat beat;
        int n;
        n = gap_len();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        beat.cmd = cmd;
        beat.req_size = req;
        beat.free_addr = fad;
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (in_stall);
        cmd_log.push_back(cmd);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (cmd_log.size() != 0) @(posedge clk);
    endtask

    task automatic free_live();
        int k;
        logic [15:0] a;
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        send_beat(CMD_FREE, 16'($urandom), a);
    endtask

    always @(posedge clk) begin
        if (!rst_n || calm) begin
            out_stall <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 99) < 35) begin
            out_stall <= 1'b1;
            stall_hold <= gap_len();
        end else begin
            out_stall <= 1'b0;
            stall_hold <= $urandom_range(0, 30);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && cmd_log.size() != 0) begin
            if (cmd_log.pop_front() == CMD_FREE) begin
                n_freed++;
            end else if (out_data.status == ST_OK) begin
                n_granted++;
                live_addrs.push_back(out_data.payload_addr);
            end else if (out_data.status == ST_ZERO) begin
                n_zero++;
            end else begin
                n_full++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int r;
        int done;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero size, heap full and ignored free addresses on an empty heap.
        send_beat(CMD_ALLOC, 16'd0, 16'hFFFF);
        send_beat(CMD_ALLOC, 16'hFFFF, 16'h0000);
        send_beat(CMD_ALLOC, 16'd65528, 16'h5A5A);
        send_beat(CMD_FREE, 16'hFFFF, 16'd0);
        send_beat(CMD_FREE, 16'h0000, 16'd4);
        send_beat(CMD_FREE, 16'h1234, 16'd10);
        send_beat(CMD_FREE, 16'hA5A5, 16'hFFFF);
        send_beat(CMD_FREE, 16'h0001, 16'hFFFC);
        // Four blocks, then frees that merge backward into one block at the heap start.
        send_beat(CMD_ALLOC, 16'd8, 16'h0000);
        send_beat(CMD_ALLOC, 16'd1, 16'h0000);
        send_beat(CMD_ALLOC, 16'd24, 16'h0000);
        send_beat(CMD_ALLOC, 16'd16, 16'h0000);
        send_beat(CMD_FREE, 16'd0, 16'd8);
        send_beat(CMD_FREE, 16'd0, 16'd24);
        send_beat(CMD_FREE, 16'd0, 16'd40);
        // Split, then a free on a stale tag whose previous free block is larger than its offset.
        send_beat(CMD_ALLOC, 16'd16, 16'h0000);
        send_beat(CMD_FREE, 16'd0, 16'd36);
        send_beat(CMD_ALLOC, 16'd24, 16'h0000);
        send_beat(CMD_ALLOC, 16'd65520, 16'h0000);
        send_beat(CMD_FREE, 16'd0, 16'd96);
        send_beat(CMD_FREE, 16'd0, 16'd72);
        send_beat(CMD_FREE, 16'd0, 16'd8);
        send_beat(CMD_FREE, 16'd0, 16'd32);
        drain();
        live_addrs.delete();

        done = 0;
        while (done < 1000) begin
            if (done == 400) drain();
            calm = (done >= 600 && done < 720);
            r = $urandom_range(0, 99);
            if (r < 45 && live_addrs.size() != 0) begin
                free_live();
                done++;
            end else if (r < 50) begin
                if (r[0]) send_beat(CMD_FREE, 16'($urandom), 16'($urandom_range(0, 7)));
                else send_beat(CMD_FREE, 16'($urandom), 16'($urandom) | 16'($urandom_range(1, 3)));
            end else if (r < 52) begin
                send_beat(CMD_ALLOC, 16'd0, 16'($urandom));
                done++;
            end else begin
                send_beat(CMD_ALLOC, small_req(), 16'($urandom));
                done++;
            end
        end
        calm = 1'b0;

        for (int i = 0; i < 60; i++) begin
            if ($urandom_range(0, 99) < 40 && live_addrs.size() != 0) free_live();
            else send_beat(CMD_ALLOC, 16'($urandom_range(1000, 12000)), 16'($urandom));
        end

        // Allocations mixed with stray frees inside the heap: stale tags, zeroed headers and double frees.
        for (int i = 0; i < 50; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35 || live_addrs.size() == 0) begin
                send_beat(CMD_ALLOC, small_req(), 16'($urandom));
            end else if (r < 60) begin
                send_beat(CMD_FREE, 16'($urandom), 16'($urandom_range(2, 4000) * 4));
            end else if (r < 75) begin
                send_beat(CMD_FREE, 16'($urandom),
                          live_addrs[$urandom_range(0, live_addrs.size() - 1)] + 16'd4);
            end else begin
                send_beat(CMD_FREE, 16'($urandom),
                          live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
            end
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Run covered %0d granted allocations, %0d zero-size and %0d heap-full results,",
                 n_granted, n_zero, n_full);
        $display("and %0d frees, with both channels idling and stalling at random.", n_freed);
        if (chk_errors == 0 && chk_waiting == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
